// ===== src/slm_pkg.sv =====
// shared constants, types and codes for the sound level meter
package slm_pkg;

   // ring geometry
   localparam int RING_DEPTH = 16;
   localparam int POS_W      = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
   localparam int FILL_W     = $clog2(RING_DEPTH + 1);

   // field widths
   localparam int SAMPLE_W = 10;
   localparam int LOUD_W   = 7;
   localparam int AVG_W    = 15;
   localparam int STATUS_W = 2;
   localparam int RANGE_W  = 7;

   // arithmetic widths
   localparam int SUM_W     = $clog2(100 * RING_DEPTH + 1);
   localparam int SCALE_W   = 17;
   localparam int DIV_NUM_W = (SUM_W + 8 > SCALE_W) ? SUM_W + 8 : SCALE_W;
   localparam int DIV_DEN_W = (FILL_W > SAMPLE_W) ? FILL_W : SAMPLE_W;
   localparam int DIV_CNT_W = $clog2(DIV_NUM_W + 1);
   localparam int PROD_W    = RANGE_W + FILL_W;
   localparam int CMP_W     = (SUM_W > PROD_W) ? SUM_W : PROD_W;

   // constants
   localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = SAMPLE_W'(1023);
   localparam logic [LOUD_W-1:0]   LOUD_MAX   = LOUD_W'(100);

   // configuration register indexes
   localparam logic [1:0] CSR_NOISE_FLOOR   = 2'd0;
   localparam logic [1:0] CSR_MAX_AMPLITUDE = 2'd1;
   localparam logic [1:0] CSR_RANGE_LOW     = 2'd2;
   localparam logic [1:0] CSR_RANGE_HIGH    = 2'd3;

   // status codes
   localparam logic [STATUS_W-1:0] STATUS_GOOD = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_POOR = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_HIGH = 2'd2;

   // divider request
   typedef struct packed {
      logic                 start;
      logic [DIV_NUM_W-1:0] dividend;
      logic [DIV_DEN_W-1:0] divisor;
   } div_req_type;

endpackage

// ===== src/sound_level_meter_unit.sv =====
// sound level meter: window peak-to-peak, loudness map, ring average, status
// samples without the last-of-window mark are taken one per cycle while idle, with
// no result; a last-of-window beat holds the input through map, loudness divide,
// store, average, average divide and result states, with two passes through the
// shared bit-serial divider, the first skipped when the loudness needs no divide;
// a stalled result adds its wait; synchronous reset loads register defaults, clears
// window, count, sum, position
module sound_level_meter_unit
   import slm_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_write_enable,
   input  logic [1:0]          csr_index,
   input  logic [SAMPLE_W-1:0] csr_write_data,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [SAMPLE_W-1:0] req_sample,
   input  logic                req_window_last,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [LOUD_W-1:0]   rsp_loudness,
   output logic [AVG_W-1:0]    rsp_average_q8,
   output logic [STATUS_W-1:0] rsp_level_status,
   output logic                rsp_was_stored
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MAP,
      ST_DIV_LOUD,
      ST_STORE,
      ST_AVERAGE,
      ST_DIV_AVG,
      ST_RESULT
   } state_type;

   state_type            state_ff, state_in;
   logic [SAMPLE_W-1:0]  noise_floor_ff, noise_floor_in;
   logic [SAMPLE_W-1:0]  max_amp_ff, max_amp_in;
   logic [RANGE_W-1:0]   range_low_ff, range_low_in;
   logic [RANGE_W-1:0]   range_high_ff, range_high_in;
   logic [SAMPLE_W-1:0]  win_min_ff, win_min_in;
   logic [SAMPLE_W-1:0]  win_max_ff, win_max_in;
   logic [SAMPLE_W-1:0]  amp_ff, amp_in;
   logic [LOUD_W-1:0]    loud_ff, loud_in;
   logic [POS_W-1:0]     pos_ff, pos_in;
   logic [FILL_W-1:0]    fill_ff, fill_in;
   logic [SUM_W-1:0]     sum_ff, sum_in;
   logic                 stored_ff, stored_in;
   logic [AVG_W-1:0]     avg_ff, avg_in;
   logic [PROD_W-1:0]    low_prod_ff, low_prod_in;
   logic [PROD_W-1:0]    high_prod_ff, high_prod_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [LOUD_W-1:0]    rsp_loud_ff, rsp_loud_in;
   logic [AVG_W-1:0]     rsp_avg_ff, rsp_avg_in;
   logic [STATUS_W-1:0]  rsp_status_ff, rsp_status_in;
   logic                 rsp_stored_ff, rsp_stored_in;

   logic                 req_beat;
   logic [SAMPLE_W-1:0]  min_upd;
   logic [SAMPLE_W-1:0]  max_upd;
   logic [SAMPLE_W-1:0]  excess;
   logic [SAMPLE_W-1:0]  span;
   logic [SCALE_W-1:0]   scaled;
   logic [LOUD_W-1:0]    old_loud;
   logic                 ring_wr;
   logic [CMP_W-1:0]     sum_cmp;
   logic [CMP_W-1:0]     low_cmp;
   logic [CMP_W-1:0]     high_cmp;
   logic [STATUS_W-1:0]  status;
   div_req_type          div_req;
   logic                 div_done;
   logic [DIV_NUM_W-1:0] div_quotient;

   slm_div u_div (
      .clock        (clock),
      .reset        (reset),
      .div_req      (div_req),
      .div_done     (div_done),
      .div_quotient (div_quotient)
   );

   slm_ring u_ring (
      .clock   (clock),
      .rd_addr (pos_ff),
      .rd_data (old_loud),
      .wr_en   (ring_wr),
      .wr_addr (pos_ff),
      .wr_data (loud_ff)
   );

   assign req_stall = (state_ff != ST_IDLE);
   assign req_beat  = req_valid && !req_stall;

   // window extremes including the incoming sample
   assign min_upd = (req_sample < win_min_ff) ? req_sample : win_min_ff;
   assign max_upd = (req_sample > win_max_ff) ? req_sample : win_max_ff;

   // linear map operands
   assign excess = amp_ff - noise_floor_ff;
   assign span   = max_amp_ff - noise_floor_ff;
   assign scaled = SCALE_W'(excess) * SCALE_W'(100);

   // status from the exact mean
   assign sum_cmp  = CMP_W'(sum_ff);
   assign low_cmp  = CMP_W'(low_prod_ff);
   assign high_cmp = CMP_W'(high_prod_ff);
   always_comb begin
      priority if (sum_cmp >= low_cmp && sum_cmp <= high_cmp) begin
         status = STATUS_GOOD;
      end else if (sum_cmp < low_cmp) begin
         status = STATUS_POOR;
      end else begin
         status = STATUS_HIGH;
      end
   end

   // next state and datapath
   always_comb begin
      state_in       = state_ff;
      noise_floor_in = noise_floor_ff;
      max_amp_in     = max_amp_ff;
      range_low_in   = range_low_ff;
      range_high_in  = range_high_ff;
      win_min_in     = win_min_ff;
      win_max_in     = win_max_ff;
      amp_in         = amp_ff;
      loud_in        = loud_ff;
      pos_in         = pos_ff;
      fill_in        = fill_ff;
      sum_in         = sum_ff;
      stored_in      = stored_ff;
      avg_in         = avg_ff;
      low_prod_in    = low_prod_ff;
      high_prod_in   = high_prod_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_loud_in    = rsp_loud_ff;
      rsp_avg_in     = rsp_avg_ff;
      rsp_status_in  = rsp_status_ff;
      rsp_stored_in  = rsp_stored_ff;
      ring_wr        = 1'b0;
      div_req        = '0;

      // configuration writes
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_NOISE_FLOOR:   noise_floor_in = csr_write_data;
            CSR_MAX_AMPLITUDE: max_amp_in     = csr_write_data;
            CSR_RANGE_LOW:     range_low_in   = csr_write_data[RANGE_W-1:0];
            CSR_RANGE_HIGH:    range_high_in  = csr_write_data[RANGE_W-1:0];
            default: ;
         endcase
      end

      // result beat taken downstream
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_beat) begin
               if (req_window_last) begin
                  amp_in     = max_upd - min_upd;
                  win_min_in = SAMPLE_MAX;
                  win_max_in = '0;
                  state_in   = ST_MAP;
               end else begin
                  win_min_in = min_upd;
                  win_max_in = max_upd;
               end
            end
         end
         ST_MAP: begin
            if (amp_ff < noise_floor_ff) begin
               loud_in  = '0;
               state_in = ST_STORE;
            end else if (max_amp_ff <= noise_floor_ff) begin
               loud_in  = LOUD_MAX;
               state_in = ST_STORE;
            end else begin
               div_req.start    = 1'b1;
               div_req.dividend = DIV_NUM_W'(scaled);
               div_req.divisor  = DIV_DEN_W'(span);
               state_in         = ST_DIV_LOUD;
            end
         end
         ST_DIV_LOUD: begin
            if (div_done) begin
               if (div_quotient > DIV_NUM_W'(LOUD_MAX)) begin
                  loud_in = LOUD_MAX;
               end else begin
                  loud_in = div_quotient[LOUD_W-1:0];
               end
               state_in = ST_STORE;
            end
         end
         ST_STORE: begin
            // read data at the write position is valid here
            stored_in = (loud_ff != '0) || (pos_ff == '0);
            if ((loud_ff != '0) || (pos_ff == '0)) begin
               ring_wr = 1'b1;
               if (fill_ff == FILL_W'(RING_DEPTH)) begin
                  sum_in = sum_ff - SUM_W'(old_loud) + SUM_W'(loud_ff);
               end else begin
                  fill_in = fill_ff + 1'b1;
                  sum_in  = sum_ff + SUM_W'(loud_ff);
               end
               if (pos_ff == POS_W'(RING_DEPTH - 1)) begin
                  pos_in = '0;
               end else begin
                  pos_in = pos_ff + 1'b1;
               end
            end
            state_in = ST_AVERAGE;
         end
         ST_AVERAGE: begin
            low_prod_in  = PROD_W'(range_low_ff) * PROD_W'(fill_ff);
            high_prod_in = PROD_W'(range_high_ff) * PROD_W'(fill_ff);
            if (fill_ff == '0) begin
               avg_in   = '0;
               state_in = ST_RESULT;
            end else begin
               div_req.start    = 1'b1;
               div_req.dividend = DIV_NUM_W'({sum_ff, 8'd0});
               div_req.divisor  = DIV_DEN_W'(fill_ff);
               state_in         = ST_DIV_AVG;
            end
         end
         ST_DIV_AVG: begin
            if (div_done) begin
               avg_in   = div_quotient[AVG_W-1:0];
               state_in = ST_RESULT;
            end
         end
         ST_RESULT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               rsp_loud_in   = loud_ff;
               rsp_avg_in    = avg_ff;
               rsp_status_in = status;
               rsp_stored_in = stored_ff;
               state_in      = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         noise_floor_ff <= SAMPLE_W'(10);
         max_amp_ff     <= SAMPLE_W'(350);
         range_low_ff   <= '0;
         range_high_ff  <= RANGE_W'(55);
         win_min_ff     <= SAMPLE_MAX;
         win_max_ff     <= '0;
         pos_ff         <= '0;
         fill_ff        <= '0;
         sum_ff         <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         noise_floor_ff <= noise_floor_in;
         max_amp_ff     <= max_amp_in;
         range_low_ff   <= range_low_in;
         range_high_ff  <= range_high_in;
         win_min_ff     <= win_min_in;
         win_max_ff     <= win_max_in;
         pos_ff         <= pos_in;
         fill_ff        <= fill_in;
         sum_ff         <= sum_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      amp_ff        <= amp_in;
      loud_ff       <= loud_in;
      stored_ff     <= stored_in;
      avg_ff        <= avg_in;
      low_prod_ff   <= low_prod_in;
      high_prod_ff  <= high_prod_in;
      rsp_loud_ff   <= rsp_loud_in;
      rsp_avg_ff    <= rsp_avg_in;
      rsp_status_ff <= rsp_status_in;
      rsp_stored_ff <= rsp_stored_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_loudness     = rsp_loud_ff;
   assign rsp_average_q8   = rsp_avg_ff;
   assign rsp_level_status = rsp_status_ff;
   assign rsp_was_stored   = rsp_stored_ff;

endmodule

// ===== src/slm_div.sv =====
// restoring divider, one quotient bit per cycle
module slm_div
   import slm_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  div_req_type          div_req,
   output logic                 div_done,
   output logic [DIV_NUM_W-1:0] div_quotient
);

   logic                 busy_ff, busy_in;
   logic [DIV_CNT_W-1:0] count_ff, count_in;
   logic [DIV_NUM_W-1:0] work_ff, work_in;
   logic [DIV_DEN_W-1:0] rem_ff, rem_in;
   logic [DIV_DEN_W-1:0] divisor_ff, divisor_in;
   logic [DIV_DEN_W:0]   rem_shift;
   logic [DIV_DEN_W:0]   rem_diff;

   // one shift and trial subtract
   always_comb begin
      rem_shift  = {rem_ff, work_ff[DIV_NUM_W-1]};
      rem_diff   = rem_shift - {1'b0, divisor_ff};
      busy_in    = busy_ff;
      count_in   = count_ff;
      work_in    = work_ff;
      rem_in     = rem_ff;
      divisor_in = divisor_ff;
      if (div_req.start) begin
         busy_in    = 1'b1;
         count_in   = DIV_CNT_W'(DIV_NUM_W);
         work_in    = div_req.dividend;
         rem_in     = '0;
         divisor_in = div_req.divisor;
      end else if (busy_ff) begin
         if (count_ff == '0) begin
            busy_in = 1'b0;
         end else begin
            count_in = count_ff - 1'b1;
            if (rem_shift >= {1'b0, divisor_ff}) begin
               rem_in  = rem_diff[DIV_DEN_W-1:0];
               work_in = {work_ff[DIV_NUM_W-2:0], 1'b1};
            end else begin
               rem_in  = rem_shift[DIV_DEN_W-1:0];
               work_in = {work_ff[DIV_NUM_W-2:0], 1'b0};
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         count_ff <= count_in;
      end
      work_ff    <= work_in;
      rem_ff     <= rem_in;
      divisor_ff <= divisor_in;
   end

   assign div_done     = busy_ff && (count_ff == '0);
   assign div_quotient = work_ff;

endmodule

// ===== src/slm_ring.sv =====
// loudness ring memory, one write and one registered read per cycle
module slm_ring
   import slm_pkg::*;
(
   input  logic              clock,
   input  logic [POS_W-1:0]  rd_addr,
   output logic [LOUD_W-1:0] rd_data,
   input  logic              wr_en,
   input  logic [POS_W-1:0]  wr_addr,
   input  logic [LOUD_W-1:0] wr_data
);

   logic [LOUD_W-1:0] ring_mem [RING_DEPTH];
   logic [LOUD_W-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         ring_mem[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= ring_mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== tb/sound_level_meter_unit_tb.sv =====
// testbench for the sound level meter: directed, pressure and random sample traffic
`timescale 1ns / 1ps

module sound_level_meter_unit_tb
   import slm_pkg::*;
;

   // register values after reset
   localparam int unsigned FLOOR_RESET      = 10;
   localparam int unsigned FULL_SCALE_RESET = 350;
   localparam int unsigned RANGE_LO_RESET   = 0;
   localparam int unsigned RANGE_HI_RESET   = 55;

   // one window close holds the input until its reading is registered
   localparam int SETTLE_CYCLES  = 100;
   localparam int HOLD_CYCLES    = 600;
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int PRINT_LIMIT    = 40;

   typedef struct packed {
      logic [LOUD_W-1:0]   loudness;
      logic [AVG_W-1:0]    average_q8;
      logic [STATUS_W-1:0] level_status;
      logic                was_stored;
   } meter_reading_type;

   logic                clock            = 1'b0;
   logic                reset            = 1'b1;
   logic                csr_write_enable = 1'b0;
   logic [1:0]          csr_index        = CSR_NOISE_FLOOR;
   logic [SAMPLE_W-1:0] csr_write_data   = '0;
   logic                req_valid        = 1'b0;
   logic                req_stall;
   logic [SAMPLE_W-1:0] req_sample       = '0;
   logic                req_window_last  = 1'b0;
   logic                rsp_valid;
   logic                rsp_stall        = 1'b0;
   logic [LOUD_W-1:0]   rsp_loudness;
   logic [AVG_W-1:0]    rsp_average_q8;
   logic [STATUS_W-1:0] rsp_level_status;
   logic                rsp_was_stored;

   // predictor copy of the registers and the meter state
   int unsigned         cfg_floor;
   int unsigned         cfg_full_scale;
   int unsigned         cfg_range_lo;
   int unsigned         cfg_range_hi;
   logic [SAMPLE_W-1:0] win_lo;
   logic [SAMPLE_W-1:0] win_hi;
   logic [LOUD_W-1:0]   loud_ring [RING_DEPTH];
   int unsigned         ring_pos;
   int unsigned         ring_fill;
   int unsigned         ring_total;

   meter_reading_type expected_readings [$];
   meter_reading_type want_reading;
   logic              beat_seen;

   int send_idle_pct    = 0;
   int recv_idle_pct    = 0;
   int hold_left        = 0;
   int idle_cycles      = 0;
   int error_count      = 0;
   int beats_sent       = 0;
   int samples_accepted = 0;
   int readings_checked = 0;
   int stored_seen      = 0;
   int status_seen [3]  = '{0, 0, 0};

   sound_level_meter_unit uut (.*);

   // clock
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // receiver: random stall, or a counted hold-off when one is requested
   always @(negedge clock) begin
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   function automatic void reset_predictor();
      cfg_floor      = FLOOR_RESET;
      cfg_full_scale = FULL_SCALE_RESET;
      cfg_range_lo   = RANGE_LO_RESET;
      cfg_range_hi   = RANGE_HI_RESET;
      win_lo         = SAMPLE_MAX;
      win_hi         = '0;
      ring_pos       = 0;
      ring_fill      = 0;
      ring_total     = 0;
      foreach (loud_ring[i]) loud_ring[i] = '0;
   endfunction

   // linear map of the peak-to-peak amplitude onto 0..100
   function automatic logic [LOUD_W-1:0] loudness_of(input int unsigned amp);
      int unsigned span;
      int unsigned scaled;
      if (amp < cfg_floor) return '0;
      if (cfg_full_scale <= cfg_floor) return LOUD_MAX;
      span   = cfg_full_scale - cfg_floor;
      scaled = ((amp - cfg_floor) * LOUD_MAX) / span;
      return (scaled > LOUD_MAX) ? LOUD_MAX : LOUD_W'(scaled);
   endfunction

   // window tracking, ring update and the reading a closed window gives
   function automatic void predict_meter(input logic [SAMPLE_W-1:0] s, input logic last);
      meter_reading_type r;
      int unsigned       amp;
      int unsigned       lo_bound;
      int unsigned       hi_bound;
      if (s < win_lo) win_lo = s;
      if (s > win_hi) win_hi = s;
      if (!last) return;
      amp        = win_hi - win_lo;
      r.loudness = loudness_of(amp);
      win_lo     = SAMPLE_MAX;
      win_hi     = '0;
      r.was_stored = 1'b0;
      if (r.loudness != 0 || ring_pos == 0) begin
         if (ring_fill >= RING_DEPTH) ring_total -= loud_ring[ring_pos];
         else ring_fill++;
         loud_ring[ring_pos] = r.loudness;
         ring_total += r.loudness;
         ring_pos = (ring_pos + 1) % RING_DEPTH;
         r.was_stored = 1'b1;
      end
      r.average_q8 = (ring_fill == 0) ? '0 : AVG_W'((ring_total << 8) / ring_fill);
      // status compares the exact mean, so scale the bounds by the fill
      lo_bound = cfg_range_lo * ring_fill;
      hi_bound = cfg_range_hi * ring_fill;
      if (ring_total >= lo_bound && ring_total <= hi_bound) r.level_status = STATUS_GOOD;
      else if (ring_total < lo_bound) r.level_status = STATUS_POOR;
      else r.level_status = STATUS_HIGH;
      expected_readings.push_back(r);
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      error_count++;
      if (error_count <= PRINT_LIMIT)
         $display("[%0t] reading %0d: %s got %0d, want %0d",
                  $time, readings_checked, what, got, want);
   endtask

   // predict accepted samples, check accepted readings, watch for a hang
   always @(posedge clock) begin
      if (!reset) begin
         beat_seen = 1'b0;
         if (req_valid && !req_stall) begin
            beat_seen = 1'b1;
            samples_accepted++;
            predict_meter(req_sample, req_window_last);
         end
         if (rsp_valid && !rsp_stall) begin
            beat_seen = 1'b1;
            readings_checked++;
            if (rsp_was_stored) stored_seen++;
            if (rsp_level_status <= STATUS_HIGH) status_seen[rsp_level_status]++;
            if (expected_readings.size() == 0) begin
               report_mismatch("reading with none expected, loudness", rsp_loudness, -1);
            end else begin
               want_reading = expected_readings.pop_front();
               if (rsp_loudness !== want_reading.loudness)
                  report_mismatch("loudness", rsp_loudness, want_reading.loudness);
               if (rsp_average_q8 !== want_reading.average_q8)
                  report_mismatch("average_q8", rsp_average_q8, want_reading.average_q8);
               if (rsp_level_status !== want_reading.level_status)
                  report_mismatch("level_status", rsp_level_status,
                                  want_reading.level_status);
               if (rsp_was_stored !== want_reading.was_stored)
                  report_mismatch("was_stored", rsp_was_stored, want_reading.was_stored);
            end
         end
         if (beat_seen) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: %0d cycles without a beat, %0d readings outstanding",
                     idle_cycles, expected_readings.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
         end
      end
   end

   // one sample beat, with random idle cycles ahead of it
   task automatic send_beat(input logic [SAMPLE_W-1:0] value, input logic last);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid       <= 1'b1;
      req_sample      <= value;
      req_window_last <= last;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
      beats_sent++;
   endtask

   task automatic send_pair(input int unsigned first, input int unsigned closing);
      send_beat(SAMPLE_W'(first), 1'b0);
      send_beat(SAMPLE_W'(closing), 1'b1);
   endtask

   // one window whose peak-to-peak is aimed at the floor or the mapped span
   task automatic send_window(input int len);
      int unsigned kind;
      int unsigned reach;
      int unsigned amp;
      int unsigned base;
      int unsigned v;
      logic        rising;
      kind  = $urandom_range(9);
      reach = (cfg_full_scale > cfg_floor) ? cfg_full_scale : cfg_floor;
      reach = (kind < 2) ? cfg_floor + 2 : reach + 40;
      if (reach > SAMPLE_MAX) reach = SAMPLE_MAX;
      amp    = $urandom_range(reach, 0);
      base   = $urandom_range(SAMPLE_MAX - amp, 0);
      rising = $urandom_range(1);
      for (int i = 0; i < len; i++) begin
         if (kind == 9) v = $urandom_range(SAMPLE_MAX);
         else if (i == 0) v = rising ? base : base + amp;
         else if (i == len - 1) v = rising ? base + amp : base;
         else v = base + $urandom_range(amp, 0);
         send_beat(SAMPLE_W'(v), i == len - 1);
      end
   endtask

   function automatic int pick_window_len();
      return ($urandom_range(9) == 0) ? $urandom_range(60, 20) : $urandom_range(8, 1);
   endfunction

   // stop offering, wait for every reading, then let the block settle
   task automatic wait_results_drained();
      req_valid <= 1'b0;
      while (expected_readings.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_register(input logic [1:0] idx, input int unsigned value);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= SAMPLE_W'(value);
      @(negedge clock);
      csr_write_enable <= 1'b0;
      @(negedge clock);
      case (idx)
         CSR_NOISE_FLOOR:   cfg_floor      = value & 32'h3FF;
         CSR_MAX_AMPLITUDE: cfg_full_scale = value & 32'h3FF;
         CSR_RANGE_LOW:     cfg_range_lo   = value & 32'h7F;
         CSR_RANGE_HIGH:    cfg_range_hi   = value & 32'h7F;
         default: ;
      endcase
   endtask

   task automatic set_config(input int unsigned floor_v, input int unsigned full_v,
                             input int unsigned lo_v, input int unsigned hi_v);
      write_register(CSR_NOISE_FLOOR, floor_v);
      write_register(CSR_MAX_AMPLITUDE, full_v);
      write_register(CSR_RANGE_LOW, lo_v);
      write_register(CSR_RANGE_HIGH, hi_v);
   endtask

   // reset registers: zero, clamp, floor edges, reload after the closing sample
   task automatic test_loudness_map();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      send_beat(SAMPLE_W'(512), 1'b1);
      send_pair(0, 1023);
      send_pair(1023, 0);
      send_pair(100, 109);
      send_pair(100, 110);
      send_beat(SAMPLE_W'(200), 1'b0);
      send_beat(SAMPLE_W'(550), 1'b0);
      send_beat(SAMPLE_W'(375), 1'b1);
      send_pair(300, 480);
      send_beat(SAMPLE_W'(5), 1'b1);
   endtask

   // full scale at or under the floor maps every gated amplitude to the top
   task automatic test_map_span_not_positive();
      wait_results_drained();
      set_config(600, 600, RANGE_LO_RESET, RANGE_HI_RESET);
      send_pair(0, 700);
      send_pair(0, 599);
      wait_results_drained();
      set_config(1023, 1, RANGE_LO_RESET, RANGE_HI_RESET);
      send_pair(0, 1023);
      send_pair(1023, 1);
   endtask

   // long result hold-off while samples keep coming, so the input backs up
   task automatic test_result_backpressure();
      wait_results_drained();
      set_config(20, 300, 30, 70);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      hold_left     = HOLD_CYCLES;
      repeat (40) send_window($urandom_range(3, 1));
   endtask

   // sender goes quiet until every reading is back, then resumes
   task automatic test_sender_drain_pause();
      send_idle_pct = 32;
      recv_idle_pct = 71;
      repeat (8) send_window(pick_window_len());
      wait_results_drained();
      repeat (8) send_window(pick_window_len());
   endtask

   task automatic test_random_traffic(input int beats, input int send_pct, input int recv_pct,
                                      input int unsigned floor_v, input int unsigned full_v,
                                      input int unsigned lo_v, input int unsigned hi_v);
      int start;
      wait_results_drained();
      set_config(floor_v, full_v, lo_v, hi_v);
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      start = beats_sent;
      while (beats_sent - start < beats) send_window(pick_window_len());
   endtask

   initial begin
      reset_predictor();
      repeat (10) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_loudness_map();
      test_map_span_not_positive();
      test_result_backpressure();
      test_sender_drain_pause();
      test_random_traffic(600, 32, 71, 0, 1023, $urandom_range(40, 10), 100);
      test_random_traffic(450, 71, 32, $urandom_range(1023), $urandom_range(1023, 1), 100, 0);
      test_random_traffic(600, 0, 0, $urandom_range(60, 5), $urandom_range(500, 200),
                          $urandom_range(100), $urandom_range(100));
      wait_results_drained();

      $display("covered %0d samples in %0d closed windows, %0d loudness values stored",
               samples_accepted, readings_checked, stored_seen);
      $display("status good/poor/high %0d/%0d/%0d, %0d field errors",
               status_seen[0], status_seen[1], status_seen[2], error_count);
      if (error_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
